### design/pide_pkg.sv
// Package for the positional insert/delete array: field widths, mode and
// status codes, and the command broadcast to the storage cells.
// No dependencies.
`default_nettype none

package pide_pkg;

    localparam int MODE_W = 3;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;

    // request modes
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DISPLAY = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DELETE  = 3'd4;

    // result status
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

    // command seen by every cell in the chain
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_APPEND = 3'd1,
        CELL_INSERT = 3'd2,
        CELL_DELETE = 3'd3,
        CELL_ROTATE = 3'd4
    } t_cell_cmd;

endpackage

`default_nettype wire

### design/pide_if.sv
// Valid/ready channel interfaces for the positional insert/delete array:
// the request channel and the result channel. Depends on pide_pkg.
`default_nettype none

interface pide_req_if;
    logic                                valid;
    logic                                ready;
    logic [pide_pkg::MODE_W-1:0]         mode;
    logic [pide_pkg::POS_W-1:0]          position;
    logic signed [pide_pkg::DATA_W-1:0]  value;

    modport source (output valid, mode, position, value, input ready);
    modport sink   (input valid, mode, position, value, output ready);
endinterface

interface pide_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [pide_pkg::STAT_W-1:0]         status;
    logic signed [pide_pkg::DATA_W-1:0]  element;
    logic                                last;
    logic [pide_pkg::CNT_W-1:0]          count;

    modport source (output valid, status, element, last, count, input ready);
    modport sink   (input valid, status, element, last, count, output ready);
endinterface

`default_nettype wire

### design/pide_cell.sv
// One storage cell of the element chain. Holds one element and picks its
// next value from itself, a neighbor, or the request value. Depends on pide_pkg.
`default_nettype none

module pide_cell #(
    parameter int IDX   = 0,
    parameter int SEL_W = 7
) (
    input  wire                           i_clk,
    input  wire pide_pkg::t_cell_cmd      i_cmd,
    input  wire [SEL_W-1:0]               i_sel,
    input  wire [pide_pkg::DATA_W-1:0]    i_val,
    input  wire [pide_pkg::DATA_W-1:0]    i_prev,
    input  wire [pide_pkg::DATA_W-1:0]    i_next,
    output logic [pide_pkg::DATA_W-1:0]   o_data
);

    localparam logic [SEL_W-1:0] L_IDX = SEL_W'(IDX);

    logic [pide_pkg::DATA_W-1:0] r_data;
    logic [pide_pkg::DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_cmd)
            pide_pkg::CELL_APPEND: begin
                if (L_IDX == i_sel) n_data = i_val;
            end
            pide_pkg::CELL_INSERT: begin
                if (L_IDX > i_sel)       n_data = i_prev;
                else if (L_IDX == i_sel) n_data = i_val;
            end
            pide_pkg::CELL_DELETE: begin
                if (L_IDX >= i_sel) n_data = i_next;
            end
            pide_pkg::CELL_ROTATE: n_data = i_next;
            default:               n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

### design/positional_array_insert_delete_unit.sv
// Positional insert/delete array: top level with cell chain and control (pide_pkg, pide_if, pide_cell).
// Clear, append, insert, delete: result valid in the cycle after the accepting edge, one request
// per cycle while results are taken; the whole chain shifts in parallel.
// Display: S_SHOW registers cell 0 as the first element, then one per cycle as the chain rotates;
// one full turn of the ring per request before the next is taken, a held result pauses the rotation.
// Reset (sync, active low) clears count and control; cell contents undefined until written.
`default_nettype none

module positional_array_insert_delete_unit #(
    parameter int DEPTH = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    pide_req_if.sink   i_req,
    pide_rsp_if.source o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);          // fill count width
    localparam int W  = (CW > pide_pkg::POS_W) ? CW : pide_pkg::POS_W;
    localparam int IW = $clog2(DEPTH);              // display step width

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SHOW = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count;
    logic [W-1:0]     n_count;
    logic [IW-1:0]    r_step, n_step;

    // result register
    logic                             r_out_valid, n_out_valid;
    logic [pide_pkg::STAT_W-1:0]      r_status, n_status;
    logic [pide_pkg::DATA_W-1:0]      r_element, n_element;
    logic                             r_last, n_last;
    logic [pide_pkg::CNT_W-1:0]       r_out_count, n_out_count;

    // chain control
    pide_pkg::t_cell_cmd              w_cmd;
    logic [W-1:0]                     w_sel;
    logic [pide_pkg::DATA_W-1:0]      w_data [DEPTH];

    logic          w_out_free;
    logic          w_accept;
    logic [W-1:0]  w_count;
    logic [W-1:0]  w_pos;
    logic [W-1:0]  w_step;
    logic          w_full;
    logic          w_empty;

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_req.valid && i_req.ready;
    assign w_count    = W'(r_count);
    assign w_pos      = W'(i_req.position);
    assign w_step     = W'(r_step);
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);

    always_comb begin
        n_state     = r_state;
        n_count     = w_count;
        n_step      = r_step;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_status    = r_status;
        n_element   = r_element;
        n_last      = r_last;
        n_out_count = r_out_count;
        w_cmd       = pide_pkg::CELL_HOLD;
        w_sel       = w_pos;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // default single result: ok, no element, last
                    n_status  = pide_pkg::ST_OK;
                    n_element = '0;
                    n_last    = 1'b1;
                    n_out_valid = 1'b1;
                    case (i_req.mode)
                        pide_pkg::MODE_CLEAR: begin
                            n_count = '0;
                        end
                        pide_pkg::MODE_APPEND: begin
                            if (w_full) begin
                                n_status = pide_pkg::ST_FULL;
                            end else begin
                                w_cmd   = pide_pkg::CELL_APPEND;
                                w_sel   = w_count;
                                n_count = w_count + W'(1);
                            end
                        end
                        pide_pkg::MODE_DISPLAY: begin
                            if (w_empty) begin
                                n_status = pide_pkg::ST_EMPTY;
                            end else begin
                                // results come from the rotation steps
                                n_out_valid = r_out_valid && !o_rsp.ready;
                                n_state     = S_SHOW;
                                n_step      = '0;
                            end
                        end
                        pide_pkg::MODE_INSERT: begin
                            if (w_full) begin
                                n_status = pide_pkg::ST_FULL;
                            end else if (w_empty) begin
                                n_status = pide_pkg::ST_EMPTY;
                            end else if (w_pos > w_count) begin
                                n_status = pide_pkg::ST_BADPOS;
                            end else begin
                                w_cmd   = pide_pkg::CELL_INSERT;
                                n_count = w_count + W'(1);
                            end
                        end
                        pide_pkg::MODE_DELETE: begin
                            if (w_empty) begin
                                n_status = pide_pkg::ST_EMPTY;
                            end else if (w_pos >= w_count) begin
                                n_status = pide_pkg::ST_BADPOS;
                            end else begin
                                w_cmd   = pide_pkg::CELL_DELETE;
                                n_count = w_count - W'(1);
                            end
                        end
                        default: begin
                            // unused modes: no result, no change
                            n_out_valid = r_out_valid && !o_rsp.ready;
                        end
                    endcase
                    n_out_count = n_count[pide_pkg::CNT_W-1:0];
                end
            end
            S_SHOW: begin
                // full turn of the ring restores the original order
                if (w_out_free) begin
                    w_cmd = pide_pkg::CELL_ROTATE;
                    if (w_step < w_count) begin
                        n_out_valid = 1'b1;
                        n_status    = pide_pkg::ST_OK;
                        n_element   = w_data[0];
                        n_last      = (w_step + W'(1) == w_count);
                        n_out_count = w_count[pide_pkg::CNT_W-1:0];
                    end
                    n_step = r_step + IW'(1);
                    if (r_step == IW'(DEPTH - 1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count[CW-1:0];
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_element   <= n_element;
        r_last      <= n_last;
        r_out_count <= n_out_count;
    end

    // cell chain: upper neighbor wraps from the top cell to cell 0; cell 0 takes itself as lower neighbor
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g + 1) % DEPTH;

        pide_cell #(
            .IDX   (g),
            .SEL_W (W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_cmd  (w_cmd),
            .i_sel  (w_sel),
            .i_val  (i_req.value),
            .i_prev (w_data[PREV]),
            .i_next (w_data[NEXT]),
            .o_data (w_data[g])
        );
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.status  = r_status;
    assign o_rsp.element = r_element;
    assign o_rsp.last    = r_last;
    assign o_rsp.count   = r_out_count;

endmodule

`default_nettype wire
